// ----- rtl/ballistic_pitch_drag_solver_defines.svh -----
// ----------------------------------------------------------------------------
// Ballistic pitch solver assertion macros
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BALLISTIC_PITCH_DRAG_SOLVER_DEFINES_SVH
`define BALLISTIC_PITCH_DRAG_SOLVER_DEFINES_SVH

`ifndef SYNTHESIS
`define BPDS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define BPDS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BPDS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define BPDS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- rtl/bpds_pkg.sv -----
// ----------------------------------------------------------------------------
// Ballistic pitch solver package
// Number formats, constants, unit request types and the CORDIC angle table.
// ----------------------------------------------------------------------------
package bpds_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 18;
  localparam int WF            = 30;            // internal Q30
  localparam int SH            = WF - FRAC_BITS;
  localparam int CNT_W         = 5;             // covers the 28-entry table
  localparam int CX_W          = 50;
  localparam int Z_W           = 34;
  localparam int NORM_BIT      = 46;
  localparam int TAYLOR_TERMS  = 12;
  localparam int QUO_W         = 42;
  localparam int DIV_PRE       = QUO_W - WF;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 21;

  typedef logic signed [63:0] w_t;

  localparam w_t ONE_W       = 64'sd1 <<< WF;
  localparam w_t HALF_PI_W   = 64'sd1686629713;
  localparam w_t LN2_W       = 64'sd744261118;
  localparam w_t KINV_W      = 64'sd652032874;
  localparam w_t EXP_ARG_MAX = 64'sd20 * ONE_W;
  localparam w_t T_MAX       = 64'sd1 <<< 40;
  localparam w_t YT_LIM      = 64'sd1 <<< 46;
  localparam w_t SAT_MAG     = 64'sd1 <<< 62;
  localparam w_t PITCH_MAX_W = (HALF_PI_W + (64'sd1 <<< (SH - 1))) >>> SH;
  localparam logic signed [17:0] PITCH_MAX = PITCH_MAX_W[17:0];

  localparam logic [1:0] STAT_CONV    = 2'd0;
  localparam logic [1:0] STAT_LIMIT   = 2'd1;
  localparam logic [1:0] STAT_INVALID = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DRAG    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOL     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 2'd3;

  localparam logic [15:0] DRAG_RST    = 16'd6554;
  localparam logic [20:0] GRAVITY_RST = 21'd641512;
  localparam logic [15:0] TOL_RST     = 16'd66;
  localparam logic [3:0]  LIMIT_RST   = 4'd10;

  typedef enum logic {CORDIC_VEC, CORDIC_ROT} cordic_mode_e;

  typedef struct packed {
    logic start;
    w_t   op_a;
    w_t   op_b;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] rem0;
    logic [63:0] bits;
    logic [5:0]  count;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic         start;
    cordic_mode_e mode;
    w_t           x;
    w_t           y;
    w_t           z;
  } cor_req_t;

  function automatic logic [29:0] atan_entry(input logic [CNT_W-1:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // Q(2*FRAC_BITS) product to Q30
  function automatic w_t to_w2(input logic [37:0] p);
    w_t r;
    if (2 * FRAC_BITS >= WF) begin
      r = w_t'(p >> (2 * FRAC_BITS - WF));
    end else begin
      r = w_t'(p) <<< (WF - 2 * FRAC_BITS);
    end
    return r;
  endfunction

endpackage

// ----- rtl/bpds_req_if.sv -----
// ----------------------------------------------------------------------------
// Ballistic pitch solver request channel
// One target: distance, height and muzzle speed with valid/ready.
// ----------------------------------------------------------------------------
interface bpds_req_if;
  logic               valid;
  logic               ready;
  logic [21:0]        target_distance;
  logic signed [21:0] target_height;
  logic [21:0]        muzzle_speed;

  modport source (output valid, target_distance, target_height, muzzle_speed,
                  input ready);
  modport sink (input valid, target_distance, target_height, muzzle_speed,
                output ready);
endinterface

// ----- rtl/bpds_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Ballistic pitch solver result channel
// Pitch angle, pass count and status with valid/ready.
// ----------------------------------------------------------------------------
interface bpds_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] pitch_angle;
  logic [3:0]         passes_used;
  logic [1:0]         status;

  modport source (output valid, pitch_angle, passes_used, status, input ready);
  modport sink (input valid, pitch_angle, passes_used, status, output ready);
endinterface

// ----- rtl/bpds_mul.sv -----
// ----------------------------------------------------------------------------
// Ballistic pitch solver multiplier
// Signed Q30 product from four 32x32 partial products, saturating.
// ----------------------------------------------------------------------------
module bpds_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bpds_pkg::mul_req_t req_i,
  output logic              done_o,
  output bpds_pkg::w_t      res_o
);
  import bpds_pkg::*;

  logic         busy_q, done_q, neg_q;
  logic [1:0]   k_q;
  logic [63:0]  ma_q, mb_q;
  logic [127:0] acc_q;
  logic [31:0]  a_half, b_half;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic         sat;
  w_t           mag;

  always_comb begin
    a_half = k_q[0] ? ma_q[63:32] : ma_q[31:0];
    b_half = k_q[1] ? mb_q[63:32] : mb_q[31:0];
    pp     = a_half * b_half;
    unique case (k_q)
      2'd0:       pp_sh = {64'd0, pp};
      2'd1, 2'd2: pp_sh = {32'd0, pp, 32'd0};
      2'd3:       pp_sh = {pp, 64'd0};
    endcase
    sat   = |acc_q[127:92];
    mag   = sat ? SAT_MAG : w_t'({2'b00, acc_q[91:30]});
    res_o = neg_q ? -mag : mag;
  end

  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      k_q    <= '0;
      ma_q   <= '0;
      mb_q   <= '0;
      acc_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        k_q    <= '0;
        acc_q  <= '0;
        neg_q  <= req_i.op_a[63] ^ req_i.op_b[63];
        ma_q   <= req_i.op_a[63] ? 64'(-req_i.op_a) : 64'(req_i.op_a);
        mb_q   <= req_i.op_b[63] ? 64'(-req_i.op_b) : 64'(req_i.op_b);
      end else if (busy_q) begin
        acc_q <= acc_q + pp_sh;
        k_q   <= k_q + 2'd1;
        if (k_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/bpds_div.sv -----
// ----------------------------------------------------------------------------
// Ballistic pitch solver divider
// Restoring divider, one quotient bit per cycle from a preloaded remainder.
// ----------------------------------------------------------------------------
module bpds_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bpds_pkg::div_req_t           req_i,
  output logic                         done_o,
  output logic [bpds_pkg::QUO_W-1:0]   quo_o
);
  import bpds_pkg::*;

  logic             busy_q, done_q;
  logic [63:0]      rem_q, bits_q, den_q;
  logic [5:0]       cnt_q;
  logic [QUO_W-1:0] quo_q;
  logic [63:0]      r2;
  logic             ge;

  // remainder stays below the divisor, so its top bit is always clear
  assign r2     = {rem_q[62:0], bits_q[63]};
  assign ge     = r2 >= den_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rem_q  <= '0;
      bits_q <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        rem_q  <= req_i.rem0;
        bits_q <= req_i.bits;
        den_q  <= req_i.den;
        cnt_q  <= req_i.count;
        quo_q  <= '0;
      end else if (busy_q) begin
        rem_q  <= ge ? r2 - den_q : r2;
        bits_q <= {bits_q[62:0], 1'b0};
        quo_q  <= {quo_q[QUO_W-2:0], ge};
        cnt_q  <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/bpds_cordic.sv -----
// ----------------------------------------------------------------------------
// Ballistic pitch solver CORDIC
// One micro-rotation per cycle; vectoring gives atan2, rotation sin and cos.
// ----------------------------------------------------------------------------
module bpds_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bpds_pkg::cor_req_t req_i,
  output logic               done_o,
  output bpds_pkg::w_t       ang_o,
  output bpds_pkg::w_t       sin_o,
  output bpds_pkg::w_t       cos_o
);
  import bpds_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER} cstate_e;

  cstate_e                 state_q;
  cordic_mode_e            mode_q;
  logic                    neg_q, done_q;
  logic signed [CX_W-1:0]  cx_q, cy_q, xs, ys, orv;
  logic signed [Z_W-1:0]   z_q, tz, zc;
  logic [CNT_W-1:0]        i_q;
  logic                    pos;
  w_t                      ay;

  always_comb begin
    ay  = req_i.y[63] ? -req_i.y : req_i.y;
    orv = cx_q | cy_q;
    xs  = cx_q >>> i_q;
    ys  = cy_q >>> i_q;
    tz  = Z_W'(atan_entry(i_q));
    pos = (mode_q == CORDIC_VEC) ? cy_q[CX_W-1] : !z_q[Z_W-1];
    if (z_q[Z_W-1]) begin
      zc = '0;
    end else if (w_t'(z_q) > HALF_PI_W) begin
      zc = Z_W'(HALF_PI_W);
    end else begin
      zc = z_q;
    end
  end

  assign done_o = done_q;
  assign ang_o  = neg_q ? -w_t'(zc) : w_t'(zc);
  assign sin_o  = w_t'(cy_q);
  assign cos_o  = w_t'(cx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      mode_q  <= CORDIC_VEC;
      neg_q   <= 1'b0;
      done_q  <= 1'b0;
      cx_q    <= '0;
      cy_q    <= '0;
      z_q     <= '0;
      i_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        C_IDLE: begin
          if (req_i.start) begin
            mode_q <= req_i.mode;
            i_q    <= '0;
            if (req_i.mode == CORDIC_VEC) begin
              neg_q   <= req_i.y[63];
              cx_q    <= req_i.x[CX_W-1:0];
              cy_q    <= ay[CX_W-1:0];
              z_q     <= '0;
              state_q <= C_NORM;
            end else begin
              neg_q   <= 1'b0;
              cx_q    <= KINV_W[CX_W-1:0];
              cy_q    <= '0;
              z_q     <= req_i.z[Z_W-1:0];
              state_q <= C_ITER;
            end
          end
        end
        C_NORM: begin
          // scale both up until one reaches bit NORM_BIT
          if (|orv[CX_W-1:NORM_BIT]) begin
            state_q <= C_ITER;
          end else if (orv[NORM_BIT-1:NORM_BIT-8] == 8'd0) begin
            cx_q <= cx_q <<< 8;
            cy_q <= cy_q <<< 8;
          end else begin
            cx_q <= cx_q <<< 1;
            cy_q <= cy_q <<< 1;
          end
        end
        C_ITER: begin
          if (pos) begin
            cx_q <= cx_q - ys;
            cy_q <= cy_q + xs;
            z_q  <= z_q - tz;
          end else begin
            cx_q <= cx_q + ys;
            cy_q <= cy_q - xs;
            z_q  <= z_q + tz;
          end
          i_q <= i_q + CNT_W'(1);
          if (i_q == CNT_W'(CORDIC_STAGES - 1)) begin
            state_q <= C_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/ballistic_pitch_drag_solver.sv -----
// ----------------------------------------------------------------------------
// Ballistic pitch solver with linear drag
// Iterative launch pitch search: sequencer over shared CORDIC, mul and div.
// ----------------------------------------------------------------------------
// Usage:
//  - req_i carries one target (distance, height, muzzle speed); it is taken
//    when valid and ready are both high. ready is high only while the solver
//    is idle, so one target is worked on at a time.
//  - rsp_o returns one result per target: pitch, passes used and status.
//  - cfg_we_i writes register cfg_idx_i (drag, gravity, tolerance, pass limit)
//    with cfg_wdata_i; write only while idle.
//  - Setup per target: range reduction by ln 2, then twelve series terms
//    (one multiply and one 31-bit divide each).
//    Skipped when the drag exponent saturates.
//  - Each pass: CORDIC vectoring (normalising shifts plus 18 rotations), CORDIC
//    rotation (18), five multiplies and a 42-bit divide unless the flight time
//    saturates.
//  - Zero distance or speed skips the solve and answers with the invalid status.
//  - A finished result sits in the output register; the next target can be
//    taken while it waits, but the following result holds until it is taken.
//  - Reset returns registers to their defaults and drops any result.
// ----------------------------------------------------------------------------
`include "ballistic_pitch_drag_solver_defines.svh"

module ballistic_pitch_drag_solver (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bpds_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bpds_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  bpds_req_if.sink                            req_i,
  bpds_rsp_if.source                          rsp_o
);
  import bpds_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP_U, S_PREP_K, S_EXPRED, S_TMUL, S_TDIV, S_ATAN, S_SINCOS,
    S_DEN, S_QDIV, S_VS, S_VST, S_TT, S_GT2, S_UPD, S_OUT
  } state_e;

  // configuration registers
  logic [15:0] drag_q, tol_q;
  logic [20:0] grav_q;
  logic [3:0]  lim_q, lim_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drag_q <= DRAG_RST;
      grav_q <= GRAVITY_RST;
      tol_q  <= TOL_RST;
      lim_q  <= LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DRAG:    drag_q <= cfg_wdata_i[15:0];
        REG_GRAVITY: grav_q <= cfg_wdata_i;
        REG_TOL:     tol_q  <= cfg_wdata_i[15:0];
        REG_LIMIT:   lim_q  <= cfg_wdata_i[3:0];
      endcase
    end
  end

  assign lim_eff = (lim_q == 4'd0) ? 4'd1 : lim_q;

  state_e             state_q;
  logic               issued_q, exp_sat_q;
  logic [21:0]        dist_q, spd_q;
  logic signed [21:0] h_q;
  w_t                 r_q, kv_q, sum_q, term_q, num_q, yt_q, a_q, sn_q, cs_q;
  w_t                 den_q, t_q, vst_q, p_q;
  logic [4:0]         n_q;
  logic [3:0]         i_q, pass_q;
  logic [1:0]         status_q;

  // output register
  logic               ov_q;
  logic signed [17:0] pitch_q;
  logic [3:0]         passes_q;
  logic [1:0]         stat_out_q;

  // shared units
  mul_req_t         mul_req;
  div_req_t         div_req;
  cor_req_t         cor_req;
  logic             mul_done, div_done, cor_done;
  w_t               mul_res, cor_ang, cor_sin, cor_cos;
  logic [QUO_W-1:0] div_quo;

  bpds_mul u_mul (
    .clk_i, .rst_ni, .req_i(mul_req), .done_o(mul_done), .res_o(mul_res)
  );
  bpds_div u_div (
    .clk_i, .rst_ni, .req_i(div_req), .done_o(div_done), .quo_o(div_quo)
  );
  bpds_cordic u_cordic (
    .clk_i, .rst_ni, .req_i(cor_req), .done_o(cor_done),
    .ang_o(cor_ang), .sin_o(cor_sin), .cos_o(cor_cos)
  );

  // datapath helpers
  logic [37:0] prep_prod;
  w_t          v_w, g_w, h_w, term_nx, sum_nx, t_div, ya, dy, ady, yt_sum, pq;
  logic        converged;

  always_comb begin
    prep_prod = 38'(drag_q) * 38'((state_q == S_PREP_U) ? dist_q : spd_q);
    v_w       = w_t'(64'(spd_q)) <<< SH;
    g_w       = w_t'(64'(grav_q)) <<< SH;
    h_w       = w_t'(h_q);
    term_nx   = w_t'(64'(div_quo));
    sum_nx    = sum_q + term_nx;
    t_div     = (w_t'(64'(div_quo)) > T_MAX) ? T_MAX : w_t'(64'(div_quo));
    ya        = (vst_q - (p_q >>> 1)) >>> SH;
    dy        = h_w - ya;
    ady       = dy[63] ? -dy : dy;
    converged = ady < w_t'(64'(tol_q));
    yt_sum    = yt_q + dy;
    pq        = (a_q + (64'sd1 <<< (SH - 1))) >>> SH;
    if (pq > w_t'(PITCH_MAX)) begin
      pq = w_t'(PITCH_MAX);
    end else if (pq < -w_t'(PITCH_MAX)) begin
      pq = -w_t'(PITCH_MAX);
    end
  end

  always_comb begin
    mul_req = '0;
    div_req = '0;
    cor_req = '0;
    unique case (state_q)
      S_TMUL: begin
        mul_req.start = !issued_q;
        mul_req.op_a  = term_q;
        mul_req.op_b  = r_q;
      end
      S_TDIV: begin
        div_req.start = !issued_q;
        div_req.bits  = {term_q[30:0], 33'd0};
        div_req.count = 6'd31;
        div_req.den   = 64'(i_q);
      end
      S_ATAN: begin
        cor_req.start = !issued_q;
        cor_req.mode  = CORDIC_VEC;
        cor_req.x     = w_t'(64'(dist_q));
        cor_req.y     = yt_q;
      end
      S_SINCOS: begin
        cor_req.start = !issued_q;
        cor_req.mode  = CORDIC_ROT;
        cor_req.z     = a_q;
      end
      S_DEN: begin
        mul_req.start = !issued_q;
        mul_req.op_a  = kv_q;
        mul_req.op_b  = cs_q;
      end
      S_QDIV: begin
        // quotient bits from 2^41 down: remainder holds the upper numerator
        div_req.start = !issued_q;
        div_req.rem0  = 64'(num_q >>> DIV_PRE);
        div_req.bits  = {num_q[DIV_PRE-1:0], (64 - DIV_PRE)'(0)};
        div_req.count = 6'(QUO_W);
        div_req.den   = 64'(den_q);
      end
      S_VS: begin
        mul_req.start = !issued_q;
        mul_req.op_a  = v_w;
        mul_req.op_b  = sn_q;
      end
      S_VST: begin
        mul_req.start = !issued_q;
        mul_req.op_a  = p_q;
        mul_req.op_b  = t_q;
      end
      S_TT: begin
        mul_req.start = !issued_q;
        mul_req.op_a  = t_q;
        mul_req.op_b  = t_q;
      end
      S_GT2: begin
        mul_req.start = !issued_q;
        mul_req.op_a  = g_w;
        mul_req.op_b  = p_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      issued_q  <= 1'b0;
      exp_sat_q <= 1'b0;
      dist_q    <= '0;
      spd_q     <= '0;
      h_q       <= '0;
      r_q       <= '0;
      kv_q      <= '0;
      sum_q     <= '0;
      term_q    <= '0;
      num_q     <= '0;
      yt_q      <= '0;
      a_q       <= '0;
      sn_q      <= '0;
      cs_q      <= '0;
      den_q     <= '0;
      t_q       <= '0;
      vst_q     <= '0;
      p_q       <= '0;
      n_q       <= '0;
      i_q       <= '0;
      pass_q    <= '0;
      status_q  <= STAT_CONV;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            dist_q   <= req_i.target_distance;
            spd_q    <= req_i.muzzle_speed;
            h_q      <= req_i.target_height;
            yt_q     <= w_t'(req_i.target_height);
            a_q      <= '0;
            pass_q   <= '0;
            num_q    <= '0;
            issued_q <= 1'b0;
            if (req_i.target_distance == 22'd0 || req_i.muzzle_speed == 22'd0) begin
              status_q <= STAT_INVALID;
              state_q  <= S_OUT;
            end else begin
              state_q <= S_PREP_U;
            end
          end
        end
        S_PREP_U: begin
          r_q       <= to_w2(prep_prod);
          exp_sat_q <= to_w2(prep_prod) > EXP_ARG_MAX;
          state_q   <= S_PREP_K;
        end
        S_PREP_K: begin
          kv_q    <= to_w2(prep_prod);
          n_q     <= '0;
          sum_q   <= ONE_W;
          term_q  <= ONE_W;
          i_q     <= 4'd1;
          state_q <= exp_sat_q ? S_ATAN : S_EXPRED;
        end
        S_EXPRED: begin
          // range reduction by ln 2, one subtract per cycle
          if (r_q >= LN2_W) begin
            r_q <= r_q - LN2_W;
            n_q <= n_q + 5'd1;
          end else begin
            state_q <= S_TMUL;
          end
        end
        S_TMUL: begin
          issued_q <= 1'b1;
          if (mul_done) begin
            term_q   <= mul_res;
            issued_q <= 1'b0;
            state_q  <= S_TDIV;
          end
        end
        S_TDIV: begin
          issued_q <= 1'b1;
          if (div_done) begin
            term_q   <= term_nx;
            sum_q    <= sum_nx;
            i_q      <= i_q + 4'd1;
            issued_q <= 1'b0;
            if (i_q == 4'(TAYLOR_TERMS)) begin
              num_q   <= (sum_nx <<< n_q) - ONE_W;
              state_q <= S_ATAN;
            end else begin
              state_q <= S_TMUL;
            end
          end
        end
        S_ATAN: begin
          issued_q <= 1'b1;
          if (cor_done) begin
            a_q      <= cor_ang;
            issued_q <= 1'b0;
            state_q  <= S_SINCOS;
          end
        end
        S_SINCOS: begin
          issued_q <= 1'b1;
          if (cor_done) begin
            sn_q     <= cor_sin;
            cs_q     <= cor_cos;
            issued_q <= 1'b0;
            state_q  <= S_DEN;
          end
        end
        S_DEN: begin
          issued_q <= 1'b1;
          if (mul_done) begin
            den_q    <= mul_res;
            issued_q <= 1'b0;
            // flight time saturates on a large exponent, a non-positive
            // denominator or a quotient beyond the divider's range
            if (exp_sat_q || mul_res <= 0 || (num_q >>> DIV_PRE) >= mul_res) begin
              t_q     <= T_MAX;
              state_q <= S_VS;
            end else begin
              state_q <= S_QDIV;
            end
          end
        end
        S_QDIV: begin
          issued_q <= 1'b1;
          if (div_done) begin
            t_q      <= t_div;
            issued_q <= 1'b0;
            state_q  <= S_VS;
          end
        end
        S_VS: begin
          issued_q <= 1'b1;
          if (mul_done) begin
            p_q      <= mul_res;
            issued_q <= 1'b0;
            state_q  <= S_VST;
          end
        end
        S_VST: begin
          issued_q <= 1'b1;
          if (mul_done) begin
            vst_q    <= mul_res;
            issued_q <= 1'b0;
            state_q  <= S_TT;
          end
        end
        S_TT: begin
          issued_q <= 1'b1;
          if (mul_done) begin
            p_q      <= mul_res;
            issued_q <= 1'b0;
            state_q  <= S_GT2;
          end
        end
        S_GT2: begin
          issued_q <= 1'b1;
          if (mul_done) begin
            p_q      <= mul_res;
            issued_q <= 1'b0;
            state_q  <= S_UPD;
          end
        end
        S_UPD: begin
          pass_q <= pass_q + 4'd1;
          if (yt_sum > YT_LIM) begin
            yt_q <= YT_LIM;
          end else if (yt_sum < -YT_LIM) begin
            yt_q <= -YT_LIM;
          end else begin
            yt_q <= yt_sum;
          end
          if (converged) begin
            status_q <= STAT_CONV;
            state_q  <= S_OUT;
          end else if (pass_q + 4'd1 == lim_eff) begin
            status_q <= STAT_LIMIT;
            state_q  <= S_OUT;
          end else begin
            state_q <= S_ATAN;
          end
        end
        S_OUT: begin
          if (!ov_q || rsp_o.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q       <= 1'b0;
      pitch_q    <= '0;
      passes_q   <= '0;
      stat_out_q <= STAT_CONV;
    end else if (state_q == S_OUT && (!ov_q || rsp_o.ready)) begin
      ov_q       <= 1'b1;
      pitch_q    <= pq[17:0];
      passes_q   <= pass_q;
      stat_out_q <= status_q;
    end else if (rsp_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = ov_q;
  assign rsp_o.pitch_angle = pitch_q;
  assign rsp_o.passes_used = passes_q;
  assign rsp_o.status      = stat_out_q;

  `BPDS_ASSERT_IMP(a_invalid_fields, clk_i, rst_ni,
    rsp_o.valid && rsp_o.status == STAT_INVALID,
    rsp_o.passes_used == 4'd0 && rsp_o.pitch_angle == 18'sd0,
    "invalid result carries nonzero fields")
  `BPDS_ASSERT_IMP(a_valid_passes, clk_i, rst_ni,
    rsp_o.valid && rsp_o.status != STAT_INVALID,
    rsp_o.passes_used != 4'd0 && rsp_o.passes_used <= lim_eff,
    "pass count outside one to limit")
  `BPDS_ASSERT_IMP(a_pitch_range, clk_i, rst_ni,
    rsp_o.valid,
    rsp_o.pitch_angle <= PITCH_MAX && rsp_o.pitch_angle >= -PITCH_MAX,
    "pitch beyond half pi")
  `BPDS_ASSERT_NXT(a_upd_next, clk_i, rst_ni,
    state_q == S_UPD,
    state_q == S_ATAN || state_q == S_OUT,
    "update step did not loop or finish")

endmodule
